// ----- rtl/button_press_capture_assert.svh -----
// ----------------------------------------------------------------------------
// button press capture assertion macros
// shared property wrappers, clocked on clk and disabled during arst_n
// ----------------------------------------------------------------------------
`ifndef BUTTON_PRESS_CAPTURE_ASSERT_SVH
`define BUTTON_PRESS_CAPTURE_ASSERT_SVH

// same-cycle implication
`define BPC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define BPC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/bpc_pkg.sv -----
// ----------------------------------------------------------------------------
// bpc_pkg
// shared codes, defaults and payload types of the button press capture block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bpc_pkg;

	// field widths
	localparam int KEY_W   = 64;
	localparam int PAD_W   = 32;
	localparam int MOUSE_W = 8;
	localparam int CODE_W  = 6;
	localparam int BTN_W   = 5;
	localparam int CFG_W   = 6;

	// default counts
	localparam int KEY_COUNT_DEF   = 64;
	localparam int PAD_COUNT_DEF   = 32;
	localparam int MOUSE_COUNT_DEF = 8;

	// register reset values
	localparam logic [CODE_W-1:0] CANCEL_KEY_RST    = 6'd41;
	localparam logic [BTN_W-1:0]  CANCEL_BUTTON_RST = 5'd6;

	// register indexes
	localparam logic CFG_CANCEL_KEY    = 1'b0;
	localparam logic CFG_CANCEL_BUTTON = 1'b1;

	// action codes
	localparam logic [1:0] ACT_SAMPLE = 2'd0;
	localparam logic [1:0] ACT_ARM    = 2'd1;
	localparam logic [1:0] ACT_CANCEL = 2'd2;

	// binding kinds
	localparam logic [1:0] KIND_NONE  = 2'd0;
	localparam logic [1:0] KIND_KEY   = 2'd1;
	localparam logic [1:0] KIND_PAD   = 2'd2;
	localparam logic [1:0] KIND_MOUSE = 2'd3;

	// outcome codes
	localparam logic [1:0] OUT_NONE      = 2'd0;
	localparam logic [1:0] OUT_CAPTURED  = 2'd1;
	localparam logic [1:0] OUT_CANCELLED = 2'd2;

	// scan verdict for one listening frame, plus release check for draining
	typedef struct packed {
		logic [1:0]        what;
		logic [1:0]        kind;
		logic [CODE_W-1:0] code;
		logic              held;
	} scan_t;

	// one result item
	typedef struct packed {
		logic [1:0]        outcome;
		logic [1:0]        kind;
		logic [CODE_W-1:0] code;
		logic [1:0]        phase;
	} result_t;

endpackage

// ----- rtl/bpc_scan.sv -----
// ----------------------------------------------------------------------------
// bpc_scan
// new press detection, cancel match, lowest new button and release check
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bpc_scan #(
	parameter int KEY_COUNT   = bpc_pkg::KEY_COUNT_DEF,
	parameter int PAD_COUNT   = bpc_pkg::PAD_COUNT_DEF,
	parameter int MOUSE_COUNT = bpc_pkg::MOUSE_COUNT_DEF
) (
	input  logic [KEY_COUNT-1:0]         keys,
	input  logic [PAD_COUNT-1:0]         pad,
	input  logic [MOUSE_COUNT-1:0]       mouse,
	input  logic [KEY_COUNT-1:0]         prior_keys,
	input  logic [PAD_COUNT-1:0]         prior_pad,
	input  logic [MOUSE_COUNT-1:0]       prior_mouse,
	input  logic [bpc_pkg::CODE_W-1:0]   cancel_key,
	input  logic [bpc_pkg::BTN_W-1:0]    cancel_button,
	input  logic                         pad_mode,
	input  logic [1:0]                   held_kind,
	input  logic [bpc_pkg::CODE_W-1:0]   held_code,
	output bpc_pkg::scan_t               scan
);
	import bpc_pkg::*;

	logic [KEY_COUNT-1:0]   new_keys, ck_vec, key_cand, hk_vec;
	logic [PAD_COUNT-1:0]   new_pad, cb_vec, pad_cand, hp_vec;
	logic [MOUSE_COUNT-1:0] new_mouse, hm_vec;
	logic [CODE_W-1:0]      key_low, pad_low, mouse_low;
	logic                   key_cancel, pad_cancel;

	// new presses against the previous snapshot
	assign new_keys  = keys & ~prior_keys;
	assign new_pad   = pad & ~prior_pad;
	assign new_mouse = mouse & ~prior_mouse;

	// one-hot decode of cancel and held indexes; out-of-count indexes decode to zero
	always_comb begin
		for (int i = 0; i < KEY_COUNT; i++) begin
			ck_vec[i] = (cancel_key == CODE_W'(i));
			hk_vec[i] = (held_code == CODE_W'(i));
		end
		for (int i = 0; i < PAD_COUNT; i++) begin
			cb_vec[i] = (cancel_button == BTN_W'(i));
			hp_vec[i] = (held_code == CODE_W'(i));
		end
		for (int i = 0; i < MOUSE_COUNT; i++) begin
			hm_vec[i] = (held_code == CODE_W'(i));
		end
	end

	assign key_cancel = |(new_keys & ck_vec);
	assign pad_cancel = |(new_pad & cb_vec);

	// key zero and the cancel key never count as a capture
	assign key_cand = new_keys & ~ck_vec & ~KEY_COUNT'(1);
	assign pad_cand = new_pad & ~cb_vec;

	// lowest set bit of each candidate vector
	always_comb begin
		key_low   = '0;
		pad_low   = '0;
		mouse_low = '0;
		for (int i = KEY_COUNT - 1; i >= 0; i--) begin
			if (key_cand[i]) key_low = CODE_W'(i);
		end
		for (int i = PAD_COUNT - 1; i >= 0; i--) begin
			if (pad_cand[i]) pad_low = CODE_W'(i);
		end
		for (int i = MOUSE_COUNT - 1; i >= 0; i--) begin
			if (new_mouse[i]) mouse_low = CODE_W'(i);
		end
	end

	// verdict in priority order, and whether the held binding is still down
	always_comb begin
		scan.what = OUT_NONE;
		scan.kind = KIND_NONE;
		scan.code = '0;
		if (key_cancel) begin
			scan.what = OUT_CANCELLED;
			scan.kind = KIND_KEY;
			scan.code = cancel_key;
		end else if (pad_cancel) begin
			scan.what = OUT_CANCELLED;
			scan.kind = KIND_PAD;
			scan.code = CODE_W'(cancel_button);
		end else if (!pad_mode) begin
			if (|key_cand) begin
				scan.what = OUT_CAPTURED;
				scan.kind = KIND_KEY;
				scan.code = key_low;
			end else if (|new_mouse) begin
				scan.what = OUT_CAPTURED;
				scan.kind = KIND_MOUSE;
				scan.code = mouse_low;
			end
		end else if (|pad_cand) begin
			scan.what = OUT_CAPTURED;
			scan.kind = KIND_PAD;
			scan.code = pad_low;
		end
		case (held_kind)
			KIND_KEY:   scan.held = |(keys & hk_vec);
			KIND_PAD:   scan.held = |(pad & hp_vec);
			KIND_MOUSE: scan.held = |(mouse & hm_vec);
			default:    scan.held = 1'b0;
		endcase
	end

endmodule

// ----- rtl/bpc_skid.sv -----
// ----------------------------------------------------------------------------
// bpc_skid
// result register with one skid entry, stall toward the core is registered
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bpc_skid (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  bpc_pkg::result_t in_data,
	output logic             out_valid,
	input  logic             out_stall,
	output bpc_pkg::result_t out_data
);
	import bpc_pkg::*;

	`include "button_press_capture_assert.svh"

	logic    main_valid_q, skid_valid_q;
	result_t main_q, skid_q;
	logic    take, drain;

	assign in_stall  = skid_valid_q;
	assign out_valid = main_valid_q;
	assign out_data  = main_q;
	assign take      = in_valid && !skid_valid_q;
	assign drain     = main_valid_q && !out_stall;

	// occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (drain) begin
			if (skid_valid_q) begin
				skid_valid_q <= 1'b0;
			end else begin
				main_valid_q <= take;
			end
		end else if (take) begin
			if (main_valid_q) skid_valid_q <= 1'b1;
			else main_valid_q <= 1'b1;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (drain) begin
			if (skid_valid_q) main_q <= skid_q;
			else if (take) main_q <= in_data;
		end else if (take) begin
			if (main_valid_q) skid_q <= in_data;
			else main_q <= in_data;
		end
	end

	`BPC_ASSERT_NOW(a_skid_needs_main, skid_valid_q, main_valid_q, "skid entry without main entry")
	`BPC_ASSERT_NEXT(a_skid_moves_up, skid_valid_q && !out_stall, main_valid_q && !skid_valid_q, "skid entry not moved up on transfer")
	`BPC_ASSERT_NEXT(a_stalled_take_skids, take && main_valid_q && out_stall, skid_valid_q, "stalled transfer not parked in skid")

endmodule

// ----- rtl/button_press_capture.sv -----
// ----------------------------------------------------------------------------
// button_press_capture
// captures the first newly pressed key, pad or mouse button after arming
// ----------------------------------------------------------------------------
// usage:
//   input channel (in_valid / in_stall) carries one item per transfer: an arm,
//   a cancel or a frame sample with the held key, pad and mouse bitmaps.
//   every accepted item gives exactly one result on the output channel
//   (out_valid / out_stall): outcome, held binding and phase after the item.
//   a result is registered before it is offered on the output channel.
//   throughput is one item per cycle while in_stall is low; phase and snapshot
//   registers update in the transfer cycle, so the next item sees them at once.
//   results go into a result register backed by one skid entry; in_stall
//   rises only when both hold a result the receiver has not taken.
//   cancel_key and cancel_button are written through cfg_we/cfg_index/cfg_data;
//   the user must write them only while no item is in flight; the block has no check.
//   reset: phase idle, no binding, snapshots zero, cancel_key 41,
//   cancel_button 6, output empty.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module button_press_capture #(
	parameter int KEY_COUNT   = bpc_pkg::KEY_COUNT_DEF,
	parameter int PAD_COUNT   = bpc_pkg::PAD_COUNT_DEF,
	parameter int MOUSE_COUNT = bpc_pkg::MOUSE_COUNT_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration
	input  logic                          cfg_we,
	input  logic                          cfg_index,
	input  logic [bpc_pkg::CFG_W-1:0]     cfg_data,
	// input channel
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [1:0]                    action,
	input  logic                          arm_pad,
	input  logic [bpc_pkg::KEY_W-1:0]     keys_down,
	input  logic [bpc_pkg::PAD_W-1:0]     pad_down,
	input  logic [bpc_pkg::MOUSE_W-1:0]   mouse_down,
	// output channel
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [1:0]                    outcome,
	output logic [1:0]                    captured_kind,
	output logic [bpc_pkg::CODE_W-1:0]    captured_code,
	output logic [1:0]                    phase_now
);
	import bpc_pkg::*;

	`include "button_press_capture_assert.svh"

	typedef enum logic [1:0] {
		PH_IDLE   = 2'd0,
		PH_ARMING = 2'd1,
		PH_LISTEN = 2'd2,
		PH_DRAIN  = 2'd3
	} phase_t;

	phase_t                 phase_q, phase_d;
	logic                   pad_mode_q, pad_mode_d;
	logic [1:0]             pending_q, pending_d;
	logic [1:0]             held_kind_q, held_kind_d;
	logic [CODE_W-1:0]      held_code_q, held_code_d;
	logic [KEY_COUNT-1:0]   prior_keys_q, prior_keys_d, keys;
	logic [PAD_COUNT-1:0]   prior_pad_q, prior_pad_d, pad;
	logic [MOUSE_COUNT-1:0] prior_mouse_q, prior_mouse_d, mouse;
	logic [CODE_W-1:0]      cancel_key_q;
	logic [BTN_W-1:0]       cancel_button_q;
	logic [1:0]             outcome_d;
	logic                   accept;
	scan_t                  scan;
	result_t                res_d, res_out;

	assign accept = in_valid && !in_stall;

	// drop bits above the configured counts
	assign keys  = keys_down[KEY_COUNT-1:0];
	assign pad   = pad_down[PAD_COUNT-1:0];
	assign mouse = mouse_down[MOUSE_COUNT-1:0];

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cancel_key_q    <= CANCEL_KEY_RST;
			cancel_button_q <= CANCEL_BUTTON_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_CANCEL_KEY:    cancel_key_q    <= cfg_data;
				CFG_CANCEL_BUTTON: cancel_button_q <= cfg_data[BTN_W-1:0];
				default: ;
			endcase
		end
	end

	// frame scan
	bpc_scan #(
		.KEY_COUNT   (KEY_COUNT),
		.PAD_COUNT   (PAD_COUNT),
		.MOUSE_COUNT (MOUSE_COUNT)
	) u_scan (
		.keys          (keys),
		.pad           (pad),
		.mouse         (mouse),
		.prior_keys    (prior_keys_q),
		.prior_pad     (prior_pad_q),
		.prior_mouse   (prior_mouse_q),
		.cancel_key    (cancel_key_q),
		.cancel_button (cancel_button_q),
		.pad_mode      (pad_mode_q),
		.held_kind     (held_kind_q),
		.held_code     (held_code_q),
		.scan          (scan)
	);

	// next state for the item at the port
	always_comb begin
		phase_d       = phase_q;
		pad_mode_d    = pad_mode_q;
		pending_d     = pending_q;
		held_kind_d   = held_kind_q;
		held_code_d   = held_code_q;
		prior_keys_d  = prior_keys_q;
		prior_pad_d   = prior_pad_q;
		prior_mouse_d = prior_mouse_q;
		outcome_d     = OUT_NONE;
		case (action)
			ACT_ARM: begin
				pad_mode_d  = arm_pad;
				phase_d     = PH_ARMING;
				pending_d   = OUT_NONE;
				held_kind_d = KIND_NONE;
				held_code_d = '0;
			end
			ACT_CANCEL: begin
				phase_d   = PH_IDLE;
				pending_d = OUT_NONE;
			end
			ACT_SAMPLE: begin
				case (phase_q)
					PH_ARMING: begin
						prior_keys_d  = keys;
						prior_pad_d   = pad;
						prior_mouse_d = mouse;
						phase_d       = PH_LISTEN;
					end
					PH_LISTEN: begin
						prior_keys_d  = keys;
						prior_pad_d   = pad;
						prior_mouse_d = mouse;
						if (scan.what != OUT_NONE) begin
							held_kind_d = scan.kind;
							held_code_d = scan.code;
							pending_d   = scan.what;
							phase_d     = PH_DRAIN;
						end
					end
					PH_DRAIN: begin
						if (!scan.held) begin
							outcome_d = pending_q;
							pending_d = OUT_NONE;
							phase_d   = PH_IDLE;
						end
					end
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	// state update on each transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_IDLE;
			pad_mode_q    <= 1'b0;
			pending_q     <= OUT_NONE;
			held_kind_q   <= KIND_NONE;
			held_code_q   <= '0;
			prior_keys_q  <= '0;
			prior_pad_q   <= '0;
			prior_mouse_q <= '0;
		end else if (accept) begin
			phase_q       <= phase_d;
			pad_mode_q    <= pad_mode_d;
			pending_q     <= pending_d;
			held_kind_q   <= held_kind_d;
			held_code_q   <= held_code_d;
			prior_keys_q  <= prior_keys_d;
			prior_pad_q   <= prior_pad_d;
			prior_mouse_q <= prior_mouse_d;
		end
	end

	// result item
	assign res_d.outcome = outcome_d;
	assign res_d.kind    = held_kind_d;
	assign res_d.code    = held_code_d;
	assign res_d.phase   = phase_d;

	bpc_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (res_d),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (res_out)
	);

	assign outcome       = res_out.outcome;
	assign captured_kind = res_out.kind;
	assign captured_code = res_out.code;
	assign phase_now     = res_out.phase;

	`BPC_ASSERT_NOW(a_report_only_idle, out_valid && (outcome != OUT_NONE), phase_now == PH_IDLE, "outcome reported outside idle")
	`BPC_ASSERT_NOW(a_pending_in_drain, pending_q != OUT_NONE, phase_q == PH_DRAIN && held_kind_q != KIND_NONE, "pending outcome without drain")
	`BPC_ASSERT_NEXT(a_arm_clears, accept && (action == ACT_ARM), phase_q == PH_ARMING && held_kind_q == KIND_NONE, "arm did not clear binding")
	`BPC_ASSERT_NOW(a_listen_unbound, phase_q == PH_LISTEN || phase_q == PH_ARMING, held_kind_q == KIND_NONE && pending_q == OUT_NONE, "binding held while listening")

endmodule
